/* src/lkvc_pkg.sv */
// ----------------------------------------------------------------------------
// LRU key/value cache package
// Shared payload types, control structs, state type and constants.
// ----------------------------------------------------------------------------
package lkvc_pkg;

   localparam int DEFAULT_ENTRIES = 16;
   localparam int CAP_W = 5;
   localparam int KEY_W = 32;
   localparam int VAL_W = 32;

   localparam logic [CAP_W-1:0] CAP_RESET  = 5'd16;
   localparam logic [VAL_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;

   localparam logic ACTION_GET = 1'b0;
   localparam logic ACTION_SET = 1'b1;

   typedef struct packed {
      logic                    action;
      logic signed [KEY_W-1:0] lookup_key;
      logic signed [VAL_W-1:0] write_value;
   } req_type;

   typedef struct packed {
      logic                    hit;
      logic signed [VAL_W-1:0] read_value;
   } rsp_type;

   typedef enum logic {
      ST_IDLE,
      ST_UPDATE
   } lkvc_state_type;

   // controller to datapath
   typedef struct packed {
      logic lookup;
      logic commit;
   } lkvc_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_free;
   } lkvc_status_type;

endpackage

/* src/lru_key_value_cache.sv */
// ----------------------------------------------------------------------------
// LRU key/value cache
// Fully associative key/value store with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (valid/ready) carries one item: action (get/set), lookup_key,
//   write_value. rsp channel (valid/ready) returns one item per request: hit
//   and read_value (stored value on a get hit, -1 otherwise).
//   csr_write_enable/csr_write_data set capacity_in_use; write only while idle.
//   Capacity 0 acts as 1, above ENTRIES acts as ENTRIES.
// Sequence: on accept the item and its lookup result are registered; the
//   result register is written in ST_UPDATE once free, raising rsp_valid.
// Steps: a lookup (parallel key and rank compare plus value memory read),
//   then the key/rank/value update; the next item waits for that update.
// Reset: the store is empty and capacity_in_use is 16; no clearing pass.
// Stall: a result waits in the output register while the next item is
//   accepted and looked up; its update and result are held until rsp_ready.
// ----------------------------------------------------------------------------
module lru_key_value_cache #(
   parameter int ENTRIES = lkvc_pkg::DEFAULT_ENTRIES
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  lkvc_pkg::req_type           req_payload,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output lkvc_pkg::rsp_type           rsp_payload,
   input  logic                       csr_write_enable,
   input  logic [lkvc_pkg::CAP_W-1:0] csr_write_data
);
   import lkvc_pkg::*;

   lkvc_cmd_type    cmd;
   lkvc_status_type status;

   lkvc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   lkvc_datapath #(
      .ENTRIES (ENTRIES)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

endmodule

/* src/lkvc_ctrl.sv */
// ----------------------------------------------------------------------------
// LRU key/value cache controller
// Two-state sequencer: look up on accept, then commit into the output register.
// ----------------------------------------------------------------------------
module lkvc_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  lkvc_pkg::lkvc_status_type status,
   output lkvc_pkg::lkvc_cmd_type    cmd
);
   import lkvc_pkg::*;

   lkvc_state_type state_ff;
   lkvc_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_ready  = 1'b0;
      cmd.lookup = 1'b0;
      cmd.commit = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.lookup = req_valid;
            if (req_valid) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            // hold until the output register can take the result
            cmd.commit = status.out_free;
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

/* src/lkvc_datapath.sv */
// ----------------------------------------------------------------------------
// LRU key/value cache datapath
// Key and rank registers, value memory, fill count, capacity and result register.
// ----------------------------------------------------------------------------
module lkvc_datapath #(
   parameter int ENTRIES = lkvc_pkg::DEFAULT_ENTRIES
) (
   input  logic                          clock,
   input  logic                          reset,
   input  lkvc_pkg::lkvc_cmd_type         cmd,
   output lkvc_pkg::lkvc_status_type      status,
   input  lkvc_pkg::req_type              req_payload,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output lkvc_pkg::rsp_type              rsp_payload,
   input  logic                          csr_write_enable,
   input  logic [lkvc_pkg::CAP_W-1:0]    csr_write_data
);
   import lkvc_pkg::*;

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
   localparam logic [CMP_W-1:0] MAX_CAP = CMP_W'(ENTRIES);

   // storage
   logic [KEY_W-1:0] key_ff  [ENTRIES];
   logic [IDX_W-1:0] rank_ff [ENTRIES];
   logic [VAL_W-1:0] value_mem [ENTRIES];
   logic [VAL_W-1:0] rd_data_ff;

   logic [CNT_W-1:0] filled_ff, filled_in;
   logic [CAP_W-1:0] capacity_ff, capacity_in;

   // item in flight
   logic             op_set_ff;
   logic [KEY_W-1:0] cur_key_ff;
   logic [VAL_W-1:0] cur_val_ff;
   logic             hit_ff;
   logic             grow_ff;
   logic [IDX_W-1:0] slot_ff;
   logic [IDX_W-1:0] old_rank_ff;

   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_payload_ff;

   // lookup logic
   logic [ENTRIES-1:0] valid_vec;
   logic [ENTRIES-1:0] match_vec;
   logic [ENTRIES-1:0] victim_vec;
   logic [IDX_W-1:0]   hit_slot;
   logic [IDX_W-1:0]   victim_slot;
   logic [IDX_W-1:0]   hit_rank;
   logic [IDX_W-1:0]   oldest_rank;
   logic [CMP_W-1:0]   eff_cap;
   logic [CMP_W-1:0]   cap_wide;
   logic               look_hit;
   logic               look_grow;
   logic [IDX_W-1:0]   look_slot;
   logic [IDX_W-1:0]   look_rank;

   always_comb begin
      cap_wide = CMP_W'(capacity_ff);
      priority if (capacity_ff == '0) begin
         eff_cap = CMP_W'(1);
      end else if (cap_wide > MAX_CAP) begin
         eff_cap = MAX_CAP;
      end else begin
         eff_cap = cap_wide;
      end
   end

   always_comb begin
      oldest_rank = IDX_W'(filled_ff - CNT_W'(1));
      hit_slot    = '0;
      victim_slot = '0;
      hit_rank    = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         valid_vec[i]  = CNT_W'(i) < filled_ff;
         match_vec[i]  = valid_vec[i] && (key_ff[i] == req_payload.lookup_key);
         victim_vec[i] = valid_vec[i] && (rank_ff[i] == oldest_rank);
         if (match_vec[i]) begin
            hit_slot = hit_slot | IDX_W'(i);
            hit_rank = hit_rank | rank_ff[i];
         end
         if (victim_vec[i]) begin
            victim_slot = victim_slot | IDX_W'(i);
         end
      end
      look_hit  = |match_vec;
      look_grow = !look_hit && (req_payload.action == ACTION_SET)
                  && (CMP_W'(filled_ff) < eff_cap);
      priority if (look_hit) begin
         look_slot = hit_slot;
         look_rank = hit_rank;
      end else if (look_grow) begin
         // new entry enters as oldest, one past the current ranks
         look_slot = IDX_W'(filled_ff);
         look_rank = IDX_W'(filled_ff);
      end else begin
         look_slot = victim_slot;
         look_rank = oldest_rank;
      end
   end

   // latch the item and its lookup result
   always_ff @(posedge clock) begin
      if (cmd.lookup) begin
         op_set_ff   <= req_payload.action == ACTION_SET;
         cur_key_ff  <= req_payload.lookup_key;
         cur_val_ff  <= req_payload.write_value;
         hit_ff      <= look_hit;
         grow_ff     <= look_grow;
         slot_ff     <= look_slot;
         old_rank_ff <= look_rank;
         rd_data_ff  <= value_mem[hit_slot];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && op_set_ff) begin
         value_mem[slot_ff] <= cur_val_ff;
      end
   end

   // commit: on a set store the key; on a set or hit, age every entry newer than the touched one
   always_ff @(posedge clock) begin
      for (int i = 0; i < ENTRIES; i++) begin
         if (cmd.commit && (op_set_ff || hit_ff)) begin
            if (IDX_W'(i) == slot_ff) begin
               rank_ff[i] <= '0;
               if (op_set_ff) begin
                  key_ff[i] <= cur_key_ff;
               end
            end else if (valid_vec[i] && (rank_ff[i] < old_rank_ff)) begin
               rank_ff[i] <= rank_ff[i] + IDX_W'(1);
            end
         end
      end
   end

   always_comb begin
      filled_in = filled_ff;
      if (cmd.commit && grow_ff) begin
         filled_in = filled_ff + CNT_W'(1);
      end
      capacity_in = capacity_ff;
      if (csr_write_enable) begin
         capacity_in = csr_write_data;
      end
      rsp_valid_in = rsp_valid_ff;
      priority if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         filled_ff    <= '0;
         capacity_ff  <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         filled_ff    <= filled_in;
         capacity_ff  <= capacity_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_payload_ff.hit <= hit_ff;
         rsp_payload_ff.read_value <= (hit_ff && !op_set_ff) ? rd_data_ff : MISS_VALUE;
      end
   end

   assign status.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_payload     = rsp_payload_ff;

   // keys stay unique among filled entries
   assert property (@(posedge clock) disable iff (reset)
      cmd.lookup |-> $onehot0(match_vec))
      else $error("duplicate key among filled entries");

   // fill count never exceeds the array
   assert property (@(posedge clock) disable iff (reset)
      filled_ff <= CNT_W'(ENTRIES))
      else $error("fill count beyond entries");

   // a growing set adds exactly one entry
   assert property (@(posedge clock) disable iff (reset)
      cmd.commit && grow_ff |=> filled_ff == $past(filled_ff) + CNT_W'(1))
      else $error("fill count did not advance");

   // a miss never returns stored data
   assert property (@(posedge clock) disable iff (reset)
      cmd.commit && !hit_ff |=> rsp_valid && !rsp_payload.hit
                              && rsp_payload.read_value == MISS_VALUE)
      else $error("miss returned data");

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// LRU key/value cache testbench
// Drives get/set items through the request channel with random gaps, stalls
// the result channel at random, and checks every result against a built-in
// LRU predictor. Capacity is rewritten between phases: zero, one, saturating
// values, and a drop below the current fill count.
// ----------------------------------------------------------------------------
module tb;
   import lkvc_pkg::*;

   localparam int NUM_ENTRIES = DEFAULT_ENTRIES;
   localparam int KEY_POOL = 24;
   localparam int PHASE_ITEMS = 53;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_payload = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_payload;
   logic csr_write_enable = 1'b0;
   logic [CAP_W-1:0] csr_write_data = '0;

   // stimulus and scoreboard
   req_type pending_items[$];
   rsp_type expected_results[$];
   int items_pushed = 0;
   int results_checked = 0;
   int hits_seen = 0;
   int mismatches = 0;
   bit req_idle_on = 1'b1;
   bit rsp_stall_on = 1'b1;
   int req_gap = 0;
   int rsp_hold = 0;

   // predictor state
   logic [KEY_W-1:0] stored_keys[NUM_ENTRIES];
   logic [VAL_W-1:0] stored_values[NUM_ENTRIES];
   int unsigned recency[NUM_ENTRIES];
   int unsigned filled_count = 0;
   logic [CAP_W-1:0] cap_setting = CAP_RESET;

   lru_key_value_cache dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_payload(rsp_payload),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data)
   );

   always #5 clock = ~clock;

   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic int unsigned usable_capacity(logic [CAP_W-1:0] setting);
      if (setting == 0) return 1;
      if (setting > NUM_ENTRIES) return NUM_ENTRIES;
      return 32'(setting);
   endfunction

   // Every filled entry more recent than the slot ages by one.
   function automatic void make_most_recent(int unsigned slot);
      int unsigned r;
      r = recency[slot];
      for (int unsigned i = 0; i < filled_count; i++) begin
         if (recency[i] < r) recency[i] = recency[i] + 1;
      end
      recency[slot] = 0;
   endfunction

   function automatic rsp_type lookup_and_update(req_type item);
      rsp_type outcome;
      int unsigned slot;
      int unsigned oldest;
      bit found;
      outcome.hit = 1'b0;
      outcome.read_value = MISS_VALUE;
      found = 1'b0;
      slot = 0;
      for (int unsigned i = 0; i < filled_count; i++) begin
         if (!found && stored_keys[i] == item.lookup_key) begin
            found = 1'b1;
            slot = i;
         end
      end
      if (found) begin
         outcome.hit = 1'b1;
         if (item.action == ACTION_SET) stored_values[slot] = item.write_value;
         else outcome.read_value = stored_values[slot];
         make_most_recent(slot);
      end else if (item.action == ACTION_SET) begin
         if (filled_count < usable_capacity(cap_setting)) begin
            // enter as oldest, then promote
            slot = filled_count;
            recency[slot] = filled_count;
            filled_count = filled_count + 1;
         end else begin
            oldest = 0;
            for (int unsigned i = 0; i < filled_count; i++) begin
               if (recency[i] >= oldest) begin
                  oldest = recency[i];
                  slot = i;
               end
            end
         end
         stored_keys[slot] = item.lookup_key;
         stored_values[slot] = item.write_value;
         make_most_recent(slot);
      end
      return outcome;
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap <= 0;
      end else if (!req_valid || req_ready) begin
         if (req_gap != 0) begin
            req_valid <= 1'b0;
            req_gap <= req_gap - 1;
         end else if (pending_items.size() != 0) begin
            req_payload <= pending_items.pop_front();
            req_valid <= 1'b1;
            req_gap <= req_idle_on ? idle_length() : 0;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result backpressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_hold <= 0;
      end else if (rsp_hold != 0) begin
         rsp_ready <= 1'b0;
         rsp_hold <= rsp_hold - 1;
      end else begin
         rsp_ready <= 1'b1;
         if (rsp_stall_on && $urandom_range(0, 3) == 0) rsp_hold <= idle_length();
      end
   end

   // monitor: predict on accepted requests, check accepted results
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (csr_write_enable) cap_setting = csr_write_data;
         if (req_valid && req_ready) expected_results.push_back(lookup_and_update(req_payload));
         if (rsp_valid && rsp_ready) begin
            results_checked++;
            if (rsp_payload.hit) hits_seen++;
            if (expected_results.size() == 0) begin
               $error("unexpected result: hit=%0b read_value=%h",
                      rsp_payload.hit, rsp_payload.read_value);
               mismatches++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_payload.hit !== want.hit) begin
                  $error("hit: expected %0b, got %0b", want.hit, rsp_payload.hit);
                  mismatches++;
               end
               if (rsp_payload.read_value !== want.read_value) begin
                  $error("read_value: expected %h, got %h",
                         want.read_value, rsp_payload.read_value);
                  mismatches++;
               end
            end
         end
      end
   end

   task automatic add_item(logic action, logic [KEY_W-1:0] key, logic [VAL_W-1:0] value);
      req_type item;
      item.action = action;
      item.lookup_key = key;
      item.write_value = value;
      pending_items.push_back(item);
      items_pushed++;
   endtask

   task automatic wait_until_drained();
      do @(posedge clock);
      while (results_checked < items_pushed);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_capacity(logic [CAP_W-1:0] setting);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= setting;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      logic [KEY_W-1:0] key_pool[KEY_POOL];
      logic [CAP_W-1:0] phase_caps[10];
      logic [KEY_W-1:0] key;
      logic [VAL_W-1:0] value;
      int span;
      int base;
      int r;
      phase_caps = '{5'd1, 5'd0, 5'd31, 5'd2, 5'd17, 5'd4, 5'd16, 5'd3, 5'd8, 5'd16};
      key_pool[0] = 32'h8000_0000;
      key_pool[1] = 32'h7FFF_FFFF;
      key_pool[2] = 32'h0000_0000;
      key_pool[3] = 32'hFFFF_FFFF;
      for (int i = 4; i < KEY_POOL; i++) key_pool[i] = $urandom;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: empty store, key and value extremes, stored -1, overwrite
      add_item(ACTION_GET, 32'h0000_0000, 32'hFFFF_FFFF);
      add_item(ACTION_SET, 32'h7FFF_FFFF, 32'h8000_0000);
      add_item(ACTION_SET, 32'h8000_0000, 32'h7FFF_FFFF);
      add_item(ACTION_SET, 32'h0000_0000, 32'hFFFF_FFFF);
      add_item(ACTION_GET, 32'h0000_0000, 32'h1234_5678);
      add_item(ACTION_SET, 32'h0000_0000, 32'h0000_0005);
      add_item(ACTION_GET, 32'h0000_0000, 32'h0000_0000);
      add_item(ACTION_SET, 32'hFFFF_FFFF, 32'h0000_0000);
      add_item(ACTION_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      add_item(ACTION_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      add_item(ACTION_GET, 32'h7FFF_FFFF, 32'h0000_0000);
      add_item(ACTION_GET, 32'h8000_0000, 32'h0000_0000);
      add_item(ACTION_GET, 32'h0000_3039, 32'h0000_0000);
      add_item(ACTION_SET, 32'hFFFF_FFFE, 32'h0000_0001);
      add_item(ACTION_GET, 32'h0000_0001, 32'hFFFF_FFFF);
      add_item(ACTION_GET, 32'hFFFF_FFFE, 32'h0000_0000);
      add_item(ACTION_SET, 32'h8000_0000, 32'h0000_0000);
      add_item(ACTION_GET, 32'h8000_0000, 32'h7FFF_FFFF);

      for (int p = 0; p < 10; p++) begin
         wait_until_drained();
         write_capacity(phase_caps[p]);
         req_idle_on = (p % 4 != 1);
         rsp_stall_on = (p % 3 != 2);
         // keep the key range a little wider than capacity to force evictions
         span = usable_capacity(phase_caps[p]) + 3;
         base = $urandom_range(0, KEY_POOL - span);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(0, 99) < 85) key = key_pool[base + $urandom_range(0, span - 1)];
            else key = $urandom;
            r = $urandom_range(0, 99);
            if (r < 10) value = 32'hFFFF_FFFF;
            else if (r < 14) value = 32'h7FFF_FFFF;
            else if (r < 18) value = 32'h8000_0000;
            else if (r < 20) value = 32'h0000_0000;
            else value = $urandom;
            add_item(1'($urandom_range(0, 1)), key, value);
         end
      end

      wait_until_drained();
      repeat (8) @(posedge clock);
      $display("Summary: %0d requests, %0d results checked, %0d hits", items_pushed,
               results_checked, hits_seen);
      $display("Capacities zero, one, small, full and saturating, including a drop below the fill count");
      if (mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
